FILE: rtl/price_level_order_book_macros.svh
// Assertion macros used by the checker file plob_checker.sv.
// No dependencies; included by name where assertions are written.
`ifndef PRICE_LEVEL_ORDER_BOOK_MACROS_SVH
`define PRICE_LEVEL_ORDER_BOOK_MACROS_SVH

// Implication checked at every clock, off during reset.
`define PLOB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define PLOB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/plob_pkg.sv
// Shared constants, types and encoder functions of the price-level order book.
// No dependencies.
package plob_pkg;

    localparam int NUM_TICKS    = 1024;
    localparam int TICK_BITS    = $clog2(NUM_TICKS);
    localparam int QTY_BITS     = 31;
    localparam int CELL_WIDTH   = 32;
    localparam int CELL_BITS    = $clog2(CELL_WIDTH);
    localparam int NUM_CELLS    = NUM_TICKS / CELL_WIDTH;
    localparam int CELL_ID_BITS = TICK_BITS - CELL_BITS;

    localparam logic [QTY_BITS-1:0] QTY_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_MKT_LOOK,
        ST_MKT_TAKE,
        ST_WAIT1,
        ST_WAIT2,
        ST_RESULT
    } state_t;

    // Occupancy update broadcast to all cells; side 1 = bid book.
    typedef struct packed {
        logic                 set;
        logic                 clr;
        logic                 side;
        logic [TICK_BITS-1:0] tick;
    } occ_cmd_t;

    typedef struct packed {
        logic                 bid_any;
        logic [CELL_BITS-1:0] bid_idx;
        logic                 ask_any;
        logic [CELL_BITS-1:0] ask_idx;
    } cell_sum_t;

    typedef struct packed {
        logic                 bid_present;
        logic [TICK_BITS-1:0] best_bid;
        logic                 ask_present;
        logic [TICK_BITS-1:0] best_ask;
    } book_top_t;

    function automatic logic [CELL_BITS-1:0] hi_slot(input logic [CELL_WIDTH-1:0] v);
        logic [CELL_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < CELL_WIDTH; i++)
            if (v[i]) r = CELL_BITS'(i);
        return r;
    endfunction

    function automatic logic [CELL_BITS-1:0] lo_slot(input logic [CELL_WIDTH-1:0] v);
        logic [CELL_BITS-1:0] r;
        r = '0;
        for (int i = CELL_WIDTH - 1; i >= 0; i--)
            if (v[i]) r = CELL_BITS'(i);
        return r;
    endfunction

    function automatic logic [CELL_ID_BITS-1:0] hi_cell(input logic [NUM_CELLS-1:0] v);
        logic [CELL_ID_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_CELLS; i++)
            if (v[i]) r = CELL_ID_BITS'(i);
        return r;
    endfunction

    function automatic logic [CELL_ID_BITS-1:0] lo_cell(input logic [NUM_CELLS-1:0] v);
        logic [CELL_ID_BITS-1:0] r;
        r = '0;
        for (int i = NUM_CELLS - 1; i >= 0; i--)
            if (v[i]) r = CELL_ID_BITS'(i);
        return r;
    endfunction

endpackage

FILE: rtl/plob_cell.sv
// One cell of the occupancy row: a slice of bid and ask occupancy bits
// with a registered local best. Depends on plob_pkg.
module plob_cell
    import plob_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CELL_ID_BITS-1:0] cell_id,
    input  occ_cmd_t                cmd,
    output cell_sum_t               sum,
    output logic                    bit_at
);

    logic [CELL_WIDTH-1:0] bid_reg, bid_next;
    logic [CELL_WIDTH-1:0] ask_reg, ask_next;
    cell_sum_t             sum_reg, sum_next;
    logic                  sel;
    logic [CELL_BITS-1:0]  slot;

    assign sel  = (cmd.tick[TICK_BITS-1:CELL_BITS] == cell_id);
    assign slot = cmd.tick[CELL_BITS-1:0];

    always_comb
    begin
        bid_next = bid_reg;
        ask_next = ask_reg;
        if (sel && (cmd.set || cmd.clr))
        begin
            if (cmd.side)
                bid_next[slot] = cmd.set;
            else
                ask_next[slot] = cmd.set;
        end
    end

    always_comb
    begin
        sum_next.bid_any = |bid_reg;
        sum_next.bid_idx = hi_slot(bid_reg);
        sum_next.ask_any = |ask_reg;
        sum_next.ask_idx = lo_slot(ask_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bid_reg <= '0;
            ask_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            bid_reg <= bid_next;
            ask_reg <= ask_next;
            sum_reg <= sum_next;
        end
    end

    assign sum    = sum_reg;
    assign bit_at = cmd.side ? bid_reg[slot] : ask_reg[slot];

endmodule

FILE: rtl/plob_best.sv
// Second level of the best-price search across the cell row, registered.
// Depends on plob_pkg.
module plob_best
    import plob_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_sum_t sums [NUM_CELLS],
    output book_top_t top
);

    logic [NUM_CELLS-1:0]    bid_vec, ask_vec;
    logic [CELL_ID_BITS-1:0] bid_c, ask_c;
    book_top_t               top_reg, top_next;

    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            bid_vec[i] = sums[i].bid_any;
            ask_vec[i] = sums[i].ask_any;
        end
        bid_c = hi_cell(bid_vec);
        ask_c = lo_cell(ask_vec);
        top_next.bid_present = |bid_vec;
        top_next.ask_present = |ask_vec;
        top_next.best_bid = (|bid_vec) ? {bid_c, sums[bid_c].bid_idx} : '0;
        top_next.best_ask = (|ask_vec) ? {ask_c, sums[ask_c].ask_idx} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            top_reg <= '0;
        else
            top_reg <= top_next;
    end

    assign top = top_reg;

endmodule

FILE: rtl/price_level_order_book.sv
// Price-level order book. Add: ADD_RD reads the level, ADD_WR writes it (not for
// zero quantity), then WAIT1, WAIT2, RESULT. Market: per level taken, MKT_LOOK
// reads, MKT_TAKE writes, and WAIT1, WAIT2 let the occupancy search (cell row,
// then best tree) settle. One word in flight at a time. Reset clears occupancy
// and search registers at once; the level quantity memories need no clearing.
module price_level_order_book
    import plob_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic                 side,
    input  logic [TICK_BITS-1:0] price_tick,
    input  logic [QTY_BITS-1:0]  quantity,
    output logic                 done,
    output logic [QTY_BITS-1:0]  filled_quantity,
    output logic [QTY_BITS-1:0]  unfilled_quantity,
    output logic                 bid_present,
    output logic [TICK_BITS-1:0] best_bid_tick,
    output logic                 ask_present,
    output logic [TICK_BITS-1:0] best_ask_tick
);

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic                 lvl_side_reg, lvl_side_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [QTY_BITS-1:0]  q_reg, q_next;
    logic [QTY_BITS-1:0]  filled_reg, filled_next;

    logic [QTY_BITS-1:0]  bid_mem [NUM_TICKS];
    logic [QTY_BITS-1:0]  ask_mem [NUM_TICKS];
    logic [QTY_BITS-1:0]  rd_bid_reg, rd_ask_reg;
    logic [QTY_BITS-1:0]  rd_lvl;
    logic [TICK_BITS-1:0] addr;
    logic                 we;
    logic [QTY_BITS-1:0]  wd;

    occ_cmd_t             cmd;
    cell_sum_t            sums [NUM_CELLS];
    logic [NUM_CELLS-1:0] bits;
    book_top_t            top;

    logic [QTY_BITS:0]    sum_ext;
    logic [QTY_BITS-1:0]  add_val;
    logic [QTY_BITS-1:0]  exec_q;
    logic [QTY_BITS-1:0]  rest_q;
    logic                 lvl_present;
    logic [TICK_BITS-1:0] lvl_best;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++)
        begin : g_cell
            plob_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .cell_id (CELL_ID_BITS'(g)),
                .cmd     (cmd),
                .sum     (sums[g]),
                .bit_at  (bits[g])
            );
        end
    endgenerate

    plob_best u_best (
        .clk   (clk),
        .rst_n (rst_n),
        .sums  (sums),
        .top   (top)
    );

    assign rd_lvl      = lvl_side_reg ? rd_bid_reg : rd_ask_reg;
    assign lvl_present = lvl_side_reg ? top.bid_present : top.ask_present;
    assign lvl_best    = lvl_side_reg ? top.best_bid : top.best_ask;
    assign sum_ext     = {1'b0, rd_lvl} + {1'b0, q_reg};
    assign add_val     = bits[tick_reg[TICK_BITS-1:CELL_BITS]]
                         ? (sum_ext[QTY_BITS] ? QTY_MAX : sum_ext[QTY_BITS-1:0])
                         : q_reg;
    assign exec_q      = (rd_lvl < q_reg) ? rd_lvl : q_reg;
    assign rest_q      = rd_lvl - exec_q;
    assign addr        = (state_reg == ST_MKT_LOOK) ? lvl_best : tick_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (start) state_next = mode ? ST_MKT_LOOK : ST_ADD_RD;
            ST_ADD_RD:   state_next = (q_reg == '0) ? ST_WAIT1 : ST_ADD_WR;
            ST_ADD_WR:   state_next = ST_WAIT1;
            ST_MKT_LOOK: state_next = (q_reg == '0 || !lvl_present) ? ST_RESULT
                                                                      : ST_MKT_TAKE;
            ST_MKT_TAKE: state_next = ST_WAIT1;
            ST_WAIT1:    state_next = ST_WAIT2;
            ST_WAIT2:    state_next = mode_reg ? ST_MKT_LOOK : ST_RESULT;
            ST_RESULT:   state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mode_next     = mode_reg;
        lvl_side_next = lvl_side_reg;
        tick_next     = tick_reg;
        q_next        = q_reg;
        filled_next   = filled_reg;
        we            = 1'b0;
        wd            = add_val;
        cmd.set       = 1'b0;
        cmd.clr       = 1'b0;
        cmd.side      = lvl_side_reg;
        cmd.tick      = tick_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next     = mode;
                    lvl_side_next = mode ? ~side : side;
                    tick_next     = price_tick;
                    q_next        = quantity;
                    filled_next   = '0;
                end
            end
            ST_ADD_WR:
            begin
                we      = 1'b1;
                wd      = add_val;
                cmd.set = 1'b1;
            end
            ST_MKT_LOOK:
                tick_next = lvl_best;
            ST_MKT_TAKE:
            begin
                we          = 1'b1;
                wd          = rest_q;
                cmd.clr     = (rest_q == '0);
                q_next      = q_reg - exec_q;
                filled_next = filled_reg + exec_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            if (lvl_side_reg)
                bid_mem[tick_reg] <= wd;
            else
                ask_mem[tick_reg] <= wd;
        end
        rd_bid_reg <= bid_mem[addr];
        rd_ask_reg <= ask_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mode_reg     <= 1'b0;
            lvl_side_reg <= 1'b0;
            tick_reg     <= '0;
            q_reg        <= '0;
            filled_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            lvl_side_reg <= lvl_side_next;
            tick_reg     <= tick_next;
            q_reg        <= q_next;
            filled_reg   <= filled_next;
        end
    end

    assign busy              = (state_reg != ST_IDLE);
    assign done              = (state_reg == ST_RESULT);
    assign filled_quantity   = filled_reg;
    assign unfilled_quantity = mode_reg ? q_reg : '0;
    assign bid_present       = top.bid_present;
    assign best_bid_tick     = top.best_bid;
    assign ask_present       = top.ask_present;
    assign best_ask_tick     = top.best_ask;

endmodule

FILE: rtl/plob_checker.sv
// Port-level checks of the order book handshake and result word.
// Depends on plob_pkg and price_level_order_book_macros.svh; bound to the top.
`include "price_level_order_book_macros.svh"

module plob_checker
    import plob_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic                 bid_present,
    input logic [TICK_BITS-1:0] best_bid_tick,
    input logic                 ask_present,
    input logic [TICK_BITS-1:0] best_ask_tick
);

    `PLOB_ASSERT_IMP(a_done_busy, done, busy, "result word outside a busy period")
    `PLOB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted word did not set busy")
    `PLOB_ASSERT_NXT(a_done_free, done, !busy && !done, "block stayed busy after result")
    `PLOB_ASSERT_IMP(a_bid_empty, done && !bid_present, best_bid_tick == '0, "empty bid tick")
    `PLOB_ASSERT_IMP(a_ask_empty, done && !ask_present, best_ask_tick == '0, "empty ask tick")

endmodule

bind price_level_order_book plob_checker u_plob_checker (.*);

FILE: tb/testbench.sv
// Testbench for price_level_order_book: random and directed adds and market sweeps,
// checked against an in-bench book model. Depends on plob_pkg and the RTL top.
module testbench
    import plob_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [QTY_BITS-1:0]  filled;
        logic [QTY_BITS-1:0]  unfilled;
        logic                 bid_p;
        logic [TICK_BITS-1:0] bid_t;
        logic                 ask_p;
        logic [TICK_BITS-1:0] ask_t;
    } fill_word_t;

    class book_scoreboard;
        logic [QTY_BITS-1:0] bid_qty [NUM_TICKS];
        logic [QTY_BITS-1:0] ask_qty [NUM_TICKS];
        bit                  bid_occ [NUM_TICKS];
        bit                  ask_occ [NUM_TICKS];
        fill_word_t          pending [$];
        int                  errors;

        function void note_order(logic m, logic s, logic [TICK_BITS-1:0] t,
                                 logic [QTY_BITS-1:0] q);
            fill_word_t w;
            logic [QTY_BITS-1:0] left, take;
            int i;
            w = '{default: '0};
            left = q;
            if (m == 1'b0) begin
                if (q != 0) begin
                    if (s) begin
                        if (!bid_occ[t]) begin bid_qty[t] = q; bid_occ[t] = 1; end
                        else if (q > QTY_MAX - bid_qty[t]) bid_qty[t] = QTY_MAX;
                        else bid_qty[t] = bid_qty[t] + q;
                    end
                    else begin
                        if (!ask_occ[t]) begin ask_qty[t] = q; ask_occ[t] = 1; end
                        else if (q > QTY_MAX - ask_qty[t]) ask_qty[t] = QTY_MAX;
                        else ask_qty[t] = ask_qty[t] + q;
                    end
                end
                left = '0;
            end
            else if (s) begin
                for (i = 0; i < NUM_TICKS && left > 0; i++)
                    if (ask_occ[i]) begin
                        take = ask_qty[i] < left ? ask_qty[i] : left;
                        ask_qty[i] -= take;
                        left -= take;
                        if (ask_qty[i] == 0) ask_occ[i] = 0;
                    end
                w.filled = q - left;
            end
            else begin
                for (i = NUM_TICKS - 1; i >= 0 && left > 0; i--)
                    if (bid_occ[i]) begin
                        take = bid_qty[i] < left ? bid_qty[i] : left;
                        bid_qty[i] -= take;
                        left -= take;
                        if (bid_qty[i] == 0) bid_occ[i] = 0;
                    end
                w.filled = q - left;
            end
            w.unfilled = left;
            for (i = NUM_TICKS - 1; i >= 0; i--)
                if (bid_occ[i]) begin w.bid_p = 1; w.bid_t = TICK_BITS'(i); break; end
            for (i = 0; i < NUM_TICKS; i++)
                if (ask_occ[i]) begin w.ask_p = 1; w.ask_t = TICK_BITS'(i); break; end
            pending.push_back(w);
        endfunction

        function void check_fill(fill_word_t a);
            fill_word_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word filled=%0d", $time, a.filled);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.filled !== e.filled || a.unfilled !== e.unfilled
                || a.bid_p !== e.bid_p || a.bid_t !== e.bid_t
                || a.ask_p !== e.ask_p || a.ask_t !== e.ask_t) begin
                $display("%0t: expected fill %0d left %0d bid %0b/%0d ask %0b/%0d",
                         $time, e.filled, e.unfilled, e.bid_p, e.bid_t, e.ask_p, e.ask_t);
                $display("%0t: actual   fill %0d left %0d bid %0b/%0d ask %0b/%0d",
                         $time, a.filled, a.unfilled, a.bid_p, a.bid_t, a.ask_p, a.ask_t);
                errors++;
            end
        endfunction
    endclass

    logic                 clk, rst_n, start, busy, mode, side, done;
    logic [TICK_BITS-1:0] price_tick;
    logic [QTY_BITS-1:0]  quantity;
    logic [QTY_BITS-1:0]  filled_quantity, unfilled_quantity;
    logic                 bid_present, ask_present;
    logic [TICK_BITS-1:0] best_bid_tick, best_ask_tick;

    book_scoreboard sb;
    bit             calm;

    price_level_order_book uut (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_fill('{filled_quantity, unfilled_quantity, bid_present,
                            best_bid_tick, ask_present, best_ask_tick});

    task automatic send_order(logic m, logic s, logic [TICK_BITS-1:0] t,
                              logic [QTY_BITS-1:0] q);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 0;
            repeat (gap) @(posedge clk);
        end
        start <= 1;
        mode <= m;
        side <= s;
        price_tick <= t;
        quantity <= q;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_order(m, s, t, q);
    endtask

    function automatic logic [QTY_BITS-1:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return QTY_MAX - QTY_BITS'($urandom_range(0, 3));
            1: return QTY_BITS'($urandom);
            2: return '0;
            default: return QTY_BITS'($urandom_range(1, 200));
        endcase
    endfunction

    initial begin
        int n, w;
        sb = new();
        foreach (sb.bid_occ[i]) begin sb.bid_occ[i] = 0; sb.ask_occ[i] = 0; end
        calm = 0;
        rst_n = 0; start = 0; mode = 0; side = 0; price_tick = 0; quantity = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // empty book sweeps, extremes, zero adds, saturation
        send_order(1, 1, 0, 5);
        send_order(1, 0, 0, 0);
        send_order(0, 1, 0, 0);
        send_order(0, 1, 0, QTY_MAX);
        send_order(0, 1, 0, QTY_MAX);
        send_order(0, 1, 1023, 7);
        send_order(0, 0, 1023, QTY_MAX);
        send_order(0, 0, 0, 1);
        send_order(0, 0, 512, 10);
        send_order(0, 1, 341, 682);
        send_order(0, 0, 682, 'h2AAA_AAAA);
        send_order(1, 1, 555, 0);
        send_order(1, 1, 0, 6);
        send_order(1, 0, 0, 3);
        send_order(1, 0, 0, 4);
        send_order(1, 1, 0, QTY_MAX);
        send_order(1, 0, 0, QTY_MAX);
        send_order(1, 0, 0, QTY_MAX);
        send_order(1, 0, 0, 1);
        for (n = 0; n < 1600; n++) begin
            if (n > 1400) calm = 1;
            // narrow tick windows keep sweeps short and levels colliding
            w = $urandom_range(0, 9);
            if ($urandom_range(0, 3) != 0)
                send_order(0, 1'($urandom),
                           w < 8 ? TICK_BITS'(500 + $urandom_range(0, 15))
                                 : TICK_BITS'($urandom), rand_qty());
            else
                send_order(1, 1'($urandom), TICK_BITS'($urandom), rand_qty());
        end
        start <= 0;
        n = 0;
        while (sb.pending.size() != 0 && n < 100000) begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

FILE: price_level_order_book.f
+incdir+rtl
rtl/plob_pkg.sv
rtl/plob_cell.sv
rtl/plob_best.sv
rtl/price_level_order_book.sv
rtl/plob_checker.sv
tb/testbench.sv
